>>> rtl/core/sqvg_pkg.sv
// shared types, codes and sine table helper for the sprite quad vertex generator
`default_nettype none

package sqvg_pkg;

    // one input word: a sprite
    typedef struct packed {
        logic [15:0]        texture_handle;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [23:0]        size_w;
        logic [23:0]        size_h;
        logic [15:0]        angle;
        logic [15:0]        uv_x;
        logic [15:0]        uv_y;
        logic [15:0]        uv_w;
        logic [15:0]        uv_h;
        logic [7:0]         layer;
        logic               flip_y;
    } t_sprite;

    // one output word: a quad corner
    typedef struct packed {
        logic [1:0]         corner;
        logic signed [23:0] vert_x;
        logic signed [23:0] vert_y;
        logic [7:0]         vert_depth;
        logic [16:0]        vert_u;
        logic [16:0]        vert_v;
        logic [3:0]         slot_index;
        logic               slot_overflow;
        logic               last;
    } t_vertex;

    // classified sprite handed from front to back
    typedef struct packed {
        t_sprite    sprite;
        logic [3:0] slot_index;
        logic       slot_overflow;
    } t_job;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_CMP,
        FS_PUSH
    } t_front_state;

    // corner order around the quad
    localparam logic [1:0] CORNER_BL = 2'd0;
    localparam logic [1:0] CORNER_BR = 2'd1;
    localparam logic [1:0] CORNER_TR = 2'd2;
    localparam logic [1:0] CORNER_TL = 2'd3;

    // angle quadrants
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [15:0] SINE_MAX    = 16'd32767;

    // taylor series of sin(x), x in q2.30, every term truncated; result q1.15 capped
    function automatic logic [15:0] sine_from_x(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] v;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        term = ((term * x2) >> 30) / 64'd6;
        acc  = acc - term;
        term = ((term * x2) >> 30) / 64'd20;
        acc  = acc + term;
        term = ((term * x2) >> 30) / 64'd42;
        acc  = acc - term;
        term = ((term * x2) >> 30) / 64'd72;
        acc  = acc + term;
        term = ((term * x2) >> 30) / 64'd110;
        acc  = acc - term;
        term = ((term * x2) >> 30) / 64'd156;
        acc  = acc + term;
        term = ((term * x2) >> 30) / 64'd210;
        acc  = acc - term;
        v    = (acc + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[15:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/sqvg_front.sv
// front end: config register, handle substitution and texture slot lookup
`default_nettype none

module sqvg_front #(
    parameter int TEXTURE_SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  sqvg_pkg::t_sprite i_sprite,
    input  logic              i_sprite_valid,
    output logic              o_sprite_ready,
    output sqvg_pkg::t_job    o_job,
    output logic              o_job_valid,
    input  logic              i_job_ready
);

    localparam int SW = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;
    localparam int UW = $clog2(TEXTURE_SLOTS + 1);

    sqvg_pkg::t_front_state r_state;
    sqvg_pkg::t_front_state n_state;

    logic [15:0]              r_default;
    sqvg_pkg::t_sprite        r_sprite;
    sqvg_pkg::t_sprite        n_sprite;
    logic [15:0]              r_slot_handles [TEXTURE_SLOTS];
    logic [UW-1:0]            r_slots_used;
    logic [TEXTURE_SLOTS-1:0] r_match;
    logic [TEXTURE_SLOTS-1:0] w_match;

    logic          w_accept;
    logic          w_push;
    logic          w_found;
    logic [SW-1:0] w_hit_idx;
    logic          w_room;
    logic [SW-1:0] w_slot;
    logic [SW+3:0] w_slot_ext;
    logic          w_ovf;
    logic          w_store;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_sprite_valid && o_sprite_ready;
    assign w_push      = o_job_valid && i_job_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sqvg_pkg::FS_IDLE: begin
                if (i_sprite_valid) begin
                    n_state = sqvg_pkg::FS_CMP;
                end
            end
            sqvg_pkg::FS_CMP: begin
                n_state = sqvg_pkg::FS_PUSH;
            end
            sqvg_pkg::FS_PUSH: begin
                if (i_job_ready) begin
                    n_state = sqvg_pkg::FS_IDLE;
                end
            end
            default: begin
                n_state = sqvg_pkg::FS_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_sprite_ready = 1'b0;
        o_job_valid    = 1'b0;
        unique case (r_state)
            sqvg_pkg::FS_IDLE: o_sprite_ready = 1'b1;
            sqvg_pkg::FS_CMP:  o_sprite_ready = 1'b0;
            sqvg_pkg::FS_PUSH: o_job_valid    = 1'b1;
            default:           o_sprite_ready = 1'b0;
        endcase
    end

    // zero handle takes the default
    always_comb begin
        n_sprite = i_sprite;
        if (i_sprite.texture_handle == 16'd0) begin
            n_sprite.texture_handle = r_default;
        end
    end

    // compare against occupied slots only
    always_comb begin
        for (int i = 0; i < TEXTURE_SLOTS; i++) begin
            w_match[i] = (r_slot_handles[i] == r_sprite.texture_handle) &&
                         (UW'(i) < r_slots_used);
        end
    end

    // lowest matching slot wins
    always_comb begin
        w_found   = 1'b0;
        w_hit_idx = '0;
        for (int i = TEXTURE_SLOTS - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                w_found   = 1'b1;
                w_hit_idx = SW'(i);
            end
        end
    end

    assign w_room     = r_slots_used < UW'(TEXTURE_SLOTS);
    assign w_slot     = w_found ? w_hit_idx : (w_room ? r_slots_used[SW-1:0] : '0);
    assign w_ovf      = !w_found && !w_room;
    assign w_store    = w_push && !w_found && w_room;
    assign w_slot_ext = {4'd0, w_slot};

    always_comb begin
        o_job.sprite        = r_sprite;
        o_job.slot_index    = w_slot_ext[3:0];
        o_job.slot_overflow = w_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sqvg_pkg::FS_IDLE;
            r_default    <= 16'd1;
            r_slots_used <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_default <= i_cfg_data;
            end
            if (w_store) begin
                r_slots_used <= r_slots_used + UW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sprite <= n_sprite;
        end
        if (r_state == sqvg_pkg::FS_CMP) begin
            r_match <= w_match;
        end
        if (w_store) begin
            r_slot_handles[r_slots_used[SW-1:0]] <= r_sprite.texture_handle;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sqvg_queue.sv
// short job queue between front and back ends
`default_nettype none

module sqvg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sqvg_pkg::t_job i_job,
    input  logic           i_job_valid,
    output logic           o_job_ready,
    output sqvg_pkg::t_job o_job,
    output logic           o_job_valid,
    input  logic           i_job_ready
);

    localparam int PW = (sqvg_pkg::QUEUE_DEPTH > 1) ? $clog2(sqvg_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(sqvg_pkg::QUEUE_DEPTH + 1);

    sqvg_pkg::t_job r_mem [sqvg_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           w_push;
    logic           w_pop;

    assign o_job_ready = r_count < CW'(sqvg_pkg::QUEUE_DEPTH);
    assign o_job_valid = r_count != '0;
    assign o_job       = r_mem[r_rd_ptr];
    assign w_push      = i_job_valid && o_job_ready;
    assign w_pop       = o_job_valid && i_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(sqvg_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(sqvg_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sqvg_back.sv
// back end: sine lookup, rotation products, corner offsets and vertex output
`default_nettype none

module sqvg_back #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sqvg_pkg::t_job    i_job,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    output sqvg_pkg::t_vertex o_vertex,
    output logic              o_vertex_valid,
    input  logic              i_vertex_ready
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH);
    localparam int DW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int MW = 14 + DW;

    // quarter-wave table, built at elaboration
    logic [15:0] w_sine [SINE_TABLE_DEPTH];
    for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_sine
        localparam logic [63:0] X = (sqvg_pkg::PI_HALF_Q30 * 64'(gi) +
                                     64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
        assign w_sine[gi] = sqvg_pkg::sine_from_x(X);
    end

    function automatic logic signed [25:0] to_q8(input logic signed [40:0] v);
        logic signed [41:0] t;
        t = 42'(v) + 42'sd32768;
        return t[41:16];
    endfunction

    function automatic logic [23:0] sat24(input logic signed [26:0] v);
        logic [23:0] res;
        if (v > 27'sd8388607) begin
            res = 24'h7FFFFF;
        end else if (v < -27'sd8388608) begin
            res = 24'h800000;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

    // stage a: sin and cos
    logic                r_a_valid;
    sqvg_pkg::t_job      r_a_job;
    logic signed [15:0]  r_a_sin;
    logic signed [15:0]  r_a_cos;
    // stage b: products
    logic                r_b_valid;
    sqvg_pkg::t_job      r_b_job;
    logic signed [39:0]  r_b_wc;
    logic signed [39:0]  r_b_hs;
    logic signed [39:0]  r_b_hc;
    logic signed [39:0]  r_b_ws;
    // stage c: half-size offsets, held for four corners
    logic                r_c_valid;
    sqvg_pkg::t_job      r_c_job;
    logic signed [25:0]  r_c_s1x;
    logic signed [25:0]  r_c_s1y;
    logic signed [25:0]  r_c_s2x;
    logic signed [25:0]  r_c_s2y;
    logic [1:0]          r_corner;
    // output register
    logic                r_out_valid;
    sqvg_pkg::t_vertex   r_out;
    sqvg_pkg::t_vertex   n_out;

    logic              w_pop;
    logic              w_a_adv;
    logic              w_a_free;
    logic              w_b_adv;
    logic              w_b_free;
    logic              w_c_load;
    logic              w_c_done;
    logic              w_c_free;

    logic [MW-1:0]     w_phase_prod;
    logic [DW-1:0]     w_phase;
    logic [DW-1:0]     w_phase_rev;
    logic signed [15:0] w_mag_p;
    logic signed [15:0] w_mag_r;
    logic signed [15:0] w_sin;
    logic signed [15:0] w_cos;

    logic signed [24:0] w_w;
    logic signed [24:0] w_h;
    logic signed [40:0] w_sum_a;
    logic signed [40:0] w_sum_b;
    logic signed [40:0] w_sum_c;
    logic signed [40:0] w_sum_e;

    logic signed [23:0] w_px;
    logic signed [23:0] w_py;
    logic signed [26:0] w_x;
    logic signed [26:0] w_y;
    logic [16:0]        w_ul;
    logic [16:0]        w_ur;
    logic [16:0]        w_vb;
    logic [16:0]        w_vt;
    logic [16:0]        w_left;
    logic [16:0]        w_right;
    logic [16:0]        w_u;
    logic [16:0]        w_v;

    // pipeline advance, back to front
    assign w_c_load    = r_c_valid && (!r_out_valid || i_vertex_ready);
    assign w_c_done    = w_c_load && (r_corner == sqvg_pkg::CORNER_TL);
    assign w_c_free    = !r_c_valid || w_c_done;
    assign w_b_adv     = r_b_valid && w_c_free;
    assign w_b_free    = !r_b_valid || w_b_adv;
    assign w_a_adv     = r_a_valid && w_b_free;
    assign w_a_free    = !r_a_valid || w_a_adv;
    assign o_job_ready = w_a_free;
    assign w_pop       = i_job_valid && w_a_free;

    // table phase and its mirror; cos shares the phase, one quadrant on
    assign w_phase_prod = MW'(i_job.sprite.angle[13:0]) * MW'(SINE_TABLE_DEPTH);
    assign w_phase      = w_phase_prod[MW-1:14];
    assign w_phase_rev  = DW'(SINE_TABLE_DEPTH) - w_phase;
    assign w_mag_p      = w_sine[w_phase[AW-1:0]];
    assign w_mag_r      = (w_phase_rev == DW'(SINE_TABLE_DEPTH)) ? sqvg_pkg::SINE_MAX
                                                                 : w_sine[w_phase_rev[AW-1:0]];

    always_comb begin
        case (i_job.sprite.angle[15:14])
            sqvg_pkg::QUAD_0: begin
                w_sin = w_mag_p;
                w_cos = w_mag_r;
            end
            sqvg_pkg::QUAD_1: begin
                w_sin = w_mag_r;
                w_cos = -w_mag_p;
            end
            sqvg_pkg::QUAD_2: begin
                w_sin = -w_mag_p;
                w_cos = -w_mag_r;
            end
            default: begin
                w_sin = -w_mag_r;
                w_cos = w_mag_p;
            end
        endcase
    end

    assign w_w = $signed({1'b0, r_a_job.sprite.size_w});
    assign w_h = $signed({1'b0, r_a_job.sprite.size_h});

    assign w_sum_a = r_b_wc - r_b_hs;
    assign w_sum_b = r_b_hc + r_b_ws;
    assign w_sum_c = r_b_wc + r_b_hs;
    assign w_sum_e = r_b_ws - r_b_hc;

    // corner position and texture coordinates
    assign w_px    = $signed(r_c_job.sprite.pos_x);
    assign w_py    = $signed(r_c_job.sprite.pos_y);
    assign w_ul    = {1'b0, r_c_job.sprite.uv_x};
    assign w_ur    = {1'b0, r_c_job.sprite.uv_x} + {1'b0, r_c_job.sprite.uv_w};
    assign w_vb    = {1'b0, r_c_job.sprite.uv_y};
    assign w_vt    = {1'b0, r_c_job.sprite.uv_y} + {1'b0, r_c_job.sprite.uv_h};
    assign w_left  = r_c_job.sprite.flip_y ? w_ur : w_ul;
    assign w_right = r_c_job.sprite.flip_y ? w_ul : w_ur;

    always_comb begin
        case (r_corner)
            sqvg_pkg::CORNER_BL: begin
                w_x = w_px - r_c_s1x;
                w_y = w_py - r_c_s1y;
                w_u = w_left;
                w_v = w_vb;
            end
            sqvg_pkg::CORNER_BR: begin
                w_x = w_px + r_c_s2x;
                w_y = w_py + r_c_s2y;
                w_u = w_right;
                w_v = w_vb;
            end
            sqvg_pkg::CORNER_TR: begin
                w_x = w_px + r_c_s1x;
                w_y = w_py + r_c_s1y;
                w_u = w_right;
                w_v = w_vt;
            end
            default: begin
                w_x = w_px - r_c_s2x;
                w_y = w_py - r_c_s2y;
                w_u = w_left;
                w_v = w_vt;
            end
        endcase
    end

    always_comb begin
        n_out.corner        = r_corner;
        n_out.vert_x        = sat24(w_x);
        n_out.vert_y        = sat24(w_y);
        n_out.vert_depth    = r_c_job.sprite.layer;
        n_out.vert_u        = w_u;
        n_out.vert_v        = w_v;
        n_out.slot_index    = r_c_job.slot_index;
        n_out.slot_overflow = r_c_job.slot_overflow;
        n_out.last          = r_corner == sqvg_pkg::CORNER_TL;
    end

    assign o_vertex       = r_out;
    assign o_vertex_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_corner    <= sqvg_pkg::CORNER_BL;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_a_valid <= 1'b1;
            end else if (w_a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (w_a_adv) begin
                r_b_valid <= 1'b1;
            end else if (w_b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (w_b_adv) begin
                r_c_valid <= 1'b1;
            end else if (w_c_done) begin
                r_c_valid <= 1'b0;
            end
            if (w_c_load) begin
                r_corner    <= r_corner + 2'd1;
                r_out_valid <= 1'b1;
            end else if (i_vertex_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_a_job <= i_job;
            r_a_sin <= w_sin;
            r_a_cos <= w_cos;
        end
        if (w_a_adv) begin
            r_b_job <= r_a_job;
            r_b_wc  <= w_w * r_a_cos;
            r_b_hs  <= w_h * r_a_sin;
            r_b_hc  <= w_h * r_a_cos;
            r_b_ws  <= w_w * r_a_sin;
        end
        if (w_b_adv) begin
            r_c_job <= r_b_job;
            r_c_s1x <= to_q8(w_sum_a);
            r_c_s1y <= to_q8(w_sum_b);
            r_c_s2x <= to_q8(w_sum_c);
            r_c_s2y <= to_q8(w_sum_e);
        end
        if (w_c_load) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sprite_quad_vertex_generator.sv
// top level: sprite in, four rotated quad corner vertices out
// path: front states, queue, back stages a, b, c, output register; one word a cycle while taken
// output: four words per sprite, all through the single output register;
//   the front steps through accept, slot compare, then slot decide and push for each sprite
// reset: synchronous active low; empties the queue and pipeline, clears the slot fill count and
//   sets the default handle to 1; slot handle contents are not cleared, no clearing pass
`default_nettype none

module sprite_quad_vertex_generator #(
    parameter int TEXTURE_SLOTS    = 16,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // default texture handle register
    input  logic [15:0]       i_cfg_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    // sprite words in
    input  sqvg_pkg::t_sprite i_sprite,
    input  logic              i_sprite_valid,
    output logic              o_sprite_ready,
    // vertex words out
    output sqvg_pkg::t_vertex o_vertex,
    output logic              o_vertex_valid,
    input  logic              i_vertex_ready
);

    // front to queue
    sqvg_pkg::t_job w_front_job;
    logic           w_front_valid;
    logic           w_front_ready;
    // queue to back
    sqvg_pkg::t_job w_back_job;
    logic           w_back_valid;
    logic           w_back_ready;

    // front: handle zero becomes the default, then the slot table is searched;
    // a miss takes the next free slot, a miss on a full table flags overflow with slot 0
    sqvg_front #(
        .TEXTURE_SLOTS (TEXTURE_SLOTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_data     (i_cfg_data),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_sprite       (i_sprite),
        .i_sprite_valid (i_sprite_valid),
        .o_sprite_ready (o_sprite_ready),
        .o_job          (w_front_job),
        .o_job_valid    (w_front_valid),
        .i_job_ready    (w_front_ready)
    );

    // two-entry queue so the front can classify the next sprite while the back emits
    sqvg_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_front_job),
        .i_job_valid (w_front_valid),
        .o_job_ready (w_front_ready),
        .o_job       (w_back_job),
        .o_job_valid (w_back_valid),
        .i_job_ready (w_back_ready)
    );

    // back: sin/cos lookup, four products, rounded half-size offsets, then one corner
    // per cycle into the output register while the receiver takes words; stages overlap with emission
    sqvg_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (w_back_job),
        .i_job_valid    (w_back_valid),
        .o_job_ready    (w_back_ready),
        .o_vertex       (o_vertex),
        .o_vertex_valid (o_vertex_valid),
        .i_vertex_ready (i_vertex_ready)
    );

endmodule

`default_nettype wire

>>> rtl/core/sqvg_checker.sv
// port-level checks on the vertex output stream, bound to the top level
`default_nettype none

module sqvg_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input sqvg_pkg::t_vertex o_vertex,
    input logic              o_vertex_valid,
    input logic              i_vertex_ready
);

    logic [1:0] r_exp_corner;
    logic [3:0] r_slot;
    logic       r_ovf;
    logic       w_take;

    assign w_take = o_vertex_valid && i_vertex_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_corner <= sqvg_pkg::CORNER_BL;
        end else if (w_take) begin
            r_exp_corner <= o_vertex.corner + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && o_vertex.corner == sqvg_pkg::CORNER_BL) begin
            r_slot <= o_vertex.slot_index;
            r_ovf  <= o_vertex.slot_overflow;
        end
    end

    // corners come out in order, one full quad after another
    a_corner_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vertex_valid |-> o_vertex.corner == r_exp_corner)
        else $error("vertex corner out of sequence");

    // slot and overflow are the same on all four corners of a quad
    a_slot_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vertex_valid && o_vertex.corner != sqvg_pkg::CORNER_BL |->
            o_vertex.slot_index == r_slot && o_vertex.slot_overflow == r_ovf)
        else $error("slot changed within a quad");

    // an overflowed lookup reports slot zero
    a_ovf_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vertex_valid && o_vertex.slot_overflow |-> o_vertex.slot_index == 4'd0)
        else $error("overflow with nonzero slot");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vertex_valid && !i_vertex_ready |=> o_vertex_valid && $stable(o_vertex))
        else $error("output word dropped or changed under stall");

endmodule

bind sprite_quad_vertex_generator sqvg_checker u_checker (.*);

`default_nettype wire

>>> verif/tb_top.sv
// testbench for the sprite quad vertex generator with a corner word scoreboard
`timescale 1ns / 100ps

module tb_top;

    localparam int          TEXTURE_SLOTS = 16;
    localparam int          SINE_DEPTH    = 256;
    localparam int          SLOT_AW       = $clog2(TEXTURE_SLOTS);
    localparam int          SINE_AW       = $clog2(SINE_DEPTH);
    localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          DRAIN_CYCLES  = 16;
    localparam int          RANDOM_PHASES = 4;
    localparam int          PHASE_SPRITES = 18;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    // dut ports
    logic [15:0]       cfg_data     = '0;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    sqvg_pkg::t_sprite sprite_word  = '0;
    logic              sprite_valid = 1'b0;
    logic              sprite_ready;
    sqvg_pkg::t_vertex vertex_word;
    logic              vertex_valid;
    logic              vertex_ready = 1'b0;

    sprite_quad_vertex_generator #(
        .TEXTURE_SLOTS    (TEXTURE_SLOTS),
        .SINE_TABLE_DEPTH (SINE_DEPTH)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_data     (cfg_data),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_sprite       (sprite_word),
        .i_sprite_valid (sprite_valid),
        .o_sprite_ready (sprite_ready),
        .o_vertex       (vertex_word),
        .o_vertex_valid (vertex_valid),
        .i_vertex_ready (vertex_ready)
    );

    // sprites waiting to go out, and corner words the block owes us
    sqvg_pkg::t_sprite sprite_backlog[$];
    sqvg_pkg::t_vertex quad_corners_due[$];
    logic [15:0]       handle_pool[$];

    // mirror of the block state: default handle, slot table, quarter-wave sine
    logic [15:0] default_handle = 16'd1;
    logic [15:0] slot_owner[TEXTURE_SLOTS];
    int unsigned slots_taken    = 0;
    logic [15:0] quarter_wave[SINE_DEPTH];

    // pacing controls set by the sequence between phases
    logic        tx_quiet     = 1'b0;
    logic        rx_quiet     = 1'b0;
    int unsigned tx_gap       = 0;
    int unsigned rx_gap       = 0;
    logic        hold_trigger = 1'b0;
    logic        hold_done    = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;

    // taylor series to x^15, every term truncated, rounded to q1.15 and capped
    function automatic logic [15:0] taylor_sine(input int unsigned idx);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] v;
        x    = (HALF_PI_Q30 * 64'(idx) + 64'(SINE_DEPTH / 2)) / 64'(SINE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        v = (acc + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[15:0];
    endfunction

    // signed q1.15 sine of a 1/65536-turn angle, folded from the quarter wave
    function automatic longint sine_q15(input logic [15:0] a);
        int unsigned p;
        int unsigned r;
        longint      tp;
        longint      tr;
        p  = 32'(a[13:0]);
        p  = (p * SINE_DEPTH) >> 14;
        r  = SINE_DEPTH - p;
        tp = longint'(quarter_wave[SINE_AW'(p)]);
        tr = (r >= SINE_DEPTH) ? 64'sd32767 : longint'(quarter_wave[SINE_AW'(r)]);
        case (a[15:14])
            sqvg_pkg::QUAD_0: return tp;
            sqvg_pkg::QUAD_1: return tr;
            sqvg_pkg::QUAD_2: return -tp;
            default:          return -tr;
        endcase
    endfunction

    // divide by 2^16 rounding half up: half size and q15 scale in one step
    function automatic longint half_q8(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic logic [23:0] clamp24(input longint v);
        if (v > 8388607) begin
            return 24'h7FFFFF;
        end
        if (v < -8388608) begin
            return 24'h800000;
        end
        return v[23:0];
    endfunction

    // work out the four corner words of one accepted sprite and update the slot table
    task automatic expand_sprite(input sqvg_pkg::t_sprite s);
        logic [15:0]       h;
        int unsigned       slot;
        logic              found;
        logic              ovf;
        longint            px, py, w, ht, sn, cs;
        longint            s1x, s1y, s2x, s2y;
        longint            vx[4];
        longint            vy[4];
        logic [16:0]       ul, ur, vb, vt;
        logic [16:0]       us[4];
        logic [16:0]       vs[4];
        sqvg_pkg::t_vertex c;
        h     = (s.texture_handle == 16'd0) ? default_handle : s.texture_handle;
        slot  = 0;
        found = 1'b0;
        ovf   = 1'b0;
        for (int unsigned i = 0; i < slots_taken; i++) begin
            if (!found && slot_owner[SLOT_AW'(i)] == h) begin
                slot  = i;
                found = 1'b1;
            end
        end
        if (!found) begin
            if (slots_taken < TEXTURE_SLOTS) begin
                // new handle takes the next free slot
                slot                             = slots_taken;
                slot_owner[SLOT_AW'(slots_taken)] = h;
                slots_taken                      = slots_taken + 1;
            end else begin
                // table full: slot 0, flagged, nothing stored
                ovf = 1'b1;
            end
        end

        px  = longint'(s.pos_x);
        py  = longint'(s.pos_y);
        w   = longint'(s.size_w);
        ht  = longint'(s.size_h);
        sn  = sine_q15(s.angle);
        cs  = sine_q15(s.angle + 16'd16384);
        s1x = half_q8(w * cs - ht * sn);
        s1y = half_q8(ht * cs + w * sn);
        s2x = half_q8(w * cs + ht * sn);
        s2y = half_q8(w * sn - ht * cs);

        vx[sqvg_pkg::CORNER_BL] = px - s1x;
        vy[sqvg_pkg::CORNER_BL] = py - s1y;
        vx[sqvg_pkg::CORNER_BR] = px + s2x;
        vy[sqvg_pkg::CORNER_BR] = py + s2y;
        vx[sqvg_pkg::CORNER_TR] = px + s1x;
        vy[sqvg_pkg::CORNER_TR] = py + s1y;
        vx[sqvg_pkg::CORNER_TL] = px - s2x;
        vy[sqvg_pkg::CORNER_TL] = py - s2y;

        // uv rectangle; flip swaps left and right u only
        ul = {1'b0, s.uv_x};
        ur = {1'b0, s.uv_x} + {1'b0, s.uv_w};
        vb = {1'b0, s.uv_y};
        vt = {1'b0, s.uv_y} + {1'b0, s.uv_h};
        us[sqvg_pkg::CORNER_BL] = s.flip_y ? ur : ul;
        us[sqvg_pkg::CORNER_TL] = s.flip_y ? ur : ul;
        us[sqvg_pkg::CORNER_BR] = s.flip_y ? ul : ur;
        us[sqvg_pkg::CORNER_TR] = s.flip_y ? ul : ur;
        vs[sqvg_pkg::CORNER_BL] = vb;
        vs[sqvg_pkg::CORNER_BR] = vb;
        vs[sqvg_pkg::CORNER_TR] = vt;
        vs[sqvg_pkg::CORNER_TL] = vt;

        for (int k = 0; k < 4; k++) begin
            c.corner        = k[1:0];
            c.vert_x        = clamp24(vx[k[1:0]]);
            c.vert_y        = clamp24(vy[k[1:0]]);
            c.vert_depth    = s.layer;
            c.vert_u        = us[k[1:0]];
            c.vert_v        = vs[k[1:0]];
            c.slot_index    = slot[3:0];
            c.slot_overflow = ovf;
            c.last          = (k[1:0] == sqvg_pkg::CORNER_TL);
            quad_corners_due.push_back(c);
        end
    endtask

    function automatic string fmt_vertex(input sqvg_pkg::t_vertex v);
        return $sformatf("corner %0d x %0d y %0d depth %0d u %0d v %0d slot %0d ovf %0b last %0b",
                         v.corner, v.vert_x, v.vert_y, v.vert_depth, v.vert_u, v.vert_v,
                         v.slot_index, v.slot_overflow, v.last);
    endfunction

    // a sprite with every field random; sizes lean to small, full-scale and maximum
    function automatic sqvg_pkg::t_sprite random_sprite();
        sqvg_pkg::t_sprite s;
        s.texture_handle = 16'($urandom_range(0, 65535));
        s.pos_x          = 24'($urandom_range(0, 24'hFFFFFF));
        s.pos_y          = 24'($urandom_range(0, 24'hFFFFFF));
        s.angle          = 16'($urandom_range(0, 65535));
        s.uv_x           = 16'($urandom_range(0, 65535));
        s.uv_y           = 16'($urandom_range(0, 65535));
        s.uv_w           = 16'($urandom_range(0, 65535));
        s.uv_h           = 16'($urandom_range(0, 65535));
        s.layer          = 8'($urandom_range(0, 255));
        s.flip_y         = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: begin
                s.size_w = 24'($urandom_range(0, 4095));
                s.size_h = 24'($urandom_range(0, 4095));
            end
            1: begin
                s.size_w = 24'hFFFFFF;
                s.size_h = 24'($urandom_range(0, 24'hFFFFFF));
            end
            default: begin
                s.size_w = 24'($urandom_range(0, 24'hFFFFFF));
                s.size_h = 24'($urandom_range(0, 24'hFFFFFF));
            end
        endcase
        return s;
    endfunction

    function automatic sqvg_pkg::t_sprite shaped(input logic [15:0] handle,
                                                 input logic [15:0] angle,
                                                 input logic flip);
        sqvg_pkg::t_sprite s;
        s                = random_sprite();
        s.texture_handle = handle;
        s.angle          = angle;
        s.flip_y         = flip;
        return s;
    endfunction

    task automatic send(input sqvg_pkg::t_sprite s);
        sprite_backlog.push_back(s);
        if (s.texture_handle != 16'd0) begin
            handle_pool.push_back(s.texture_handle);
        end
    endtask

    // wait until every sprite is accepted and every corner word has come back
    task automatic drain();
        while (sprite_backlog.size() != 0 || sprite_valid || quad_corners_due.size() != 0) begin
            @(negedge clk);
        end
    endtask

    // register write on its own channel, only while the block is idle
    task automatic set_default_handle(input logic [15:0] value);
        @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        default_handle = value;
        cfg_valid      <= 1'b0;
        @(negedge clk);
    endtask

    // sprite driver: one word per handshake, random gap after each accepted word unless tx_quiet
    always @(posedge clk) begin
        int unsigned gap;
        logic        holding;
        if (!rst_n) begin
            sprite_valid <= 1'b0;
            tx_gap       <= 0;
        end else begin
            gap     = tx_gap;
            holding = sprite_valid;
            if (sprite_valid && sprite_ready) begin
                expand_sprite(sprite_word);
                holding = 1'b0;
                gap     = tx_quiet ? 0 : $urandom_range(0, 15);
            end
            if (!holding) begin
                if (gap != 0) begin
                    gap = gap - 1;
                end else if (sprite_backlog.size() != 0) begin
                    // next sprite goes straight out, valid is set or stays high
                    sprite_word  <= sprite_backlog.pop_front();
                    sprite_valid <= 1'b1;
                    holding      = 1'b1;
                end
            end
            if (!holding) begin
                sprite_valid <= 1'b0;
            end
            tx_gap <= gap;
        end
    end

    // one long receiver hold-off, counted here so the block backs up into its input
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_trigger && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // vertex monitor: checks each accepted word against the oldest owed corner
    always @(posedge clk) begin
        int unsigned       gap;
        sqvg_pkg::t_vertex want;
        if (!rst_n) begin
            vertex_ready <= 1'b0;
            rx_gap       <= 0;
        end else begin
            gap = rx_gap;
            if (vertex_valid && vertex_ready) begin
                if (quad_corners_due.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected vertex word: %s", fmt_vertex(vertex_word));
                    end
                    mismatches = mismatches + 1;
                end else begin
                    want = quad_corners_due.pop_front();
                    if (vertex_word.corner !== want.corner ||
                        vertex_word.vert_x !== want.vert_x ||
                        vertex_word.vert_y !== want.vert_y ||
                        vertex_word.vert_depth !== want.vert_depth ||
                        vertex_word.vert_u !== want.vert_u ||
                        vertex_word.vert_v !== want.vert_v ||
                        vertex_word.slot_index !== want.slot_index ||
                        vertex_word.slot_overflow !== want.slot_overflow ||
                        vertex_word.last !== want.last) begin
                        if (mismatches < 10) begin
                            $display("vertex mismatch at cycle %0d", cycle_count);
                            $display("  expected %s", fmt_vertex(want));
                            $display("  actual   %s", fmt_vertex(vertex_word));
                        end
                        mismatches = mismatches + 1;
                    end
                end
                gap = rx_quiet ? 0 : $urandom_range(0, 15);
            end else if (gap != 0) begin
                gap = gap - 1;
            end
            rx_gap       <= gap;
            vertex_ready <= (gap == 0) && (hold_left == 0);
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // test sequence
    initial begin
        sqvg_pkg::t_sprite s;
        int unsigned       pick;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            quarter_wave[SINE_AW'(i)] = taylor_sine(i);
        end
        for (int i = 0; i < TEXTURE_SLOTS; i++) begin
            slot_owner[SLOT_AW'(i)] = 16'd0;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default handle at its reset value: zero handle maps onto handle 1
        s         = shaped(16'd0, 16'd0, 1'b0);
        s.pos_x   = '0;
        s.pos_y   = '0;
        s.size_w  = '0;
        s.size_h  = '0;
        s.uv_x    = '0;
        s.uv_y    = '0;
        s.uv_w    = '0;
        s.uv_h    = '0;
        s.layer   = '0;
        send(s);
        // positive saturation, uv sums at their top, deepest layer
        s         = shaped(16'd1, 16'd0, 1'b0);
        s.pos_x   = 24'h7FFFFF;
        s.pos_y   = 24'h7FFFFF;
        s.size_w  = 24'hFFFFFF;
        s.size_h  = 24'hFFFFFF;
        s.uv_x    = 16'hFFFF;
        s.uv_y    = 16'hFFFF;
        s.uv_w    = 16'hFFFF;
        s.uv_h    = 16'hFFFF;
        s.layer   = 8'hFF;
        send(s);
        // negative saturation, half turn, flipped u
        s         = shaped(16'd7, 16'h8000, 1'b1);
        s.pos_x   = 24'h800000;
        s.pos_y   = 24'h800000;
        s.size_w  = 24'hFFFFFF;
        s.size_h  = 24'hFFFFFF;
        s.uv_x    = 16'hFFFF;
        s.uv_w    = 16'hFFFF;
        send(s);
        // quadrant boundaries and the top of the angle range
        send(shaped(16'd1, 16'h4000, 1'b0));
        send(shaped(16'd7, 16'hC000, 1'b1));
        send(shaped(16'd0, 16'hFFFF, 1'b0));
        send(shaped(16'd1, 16'h3FFF, 1'b1));
        send(shaped(16'd7, 16'h2000, 1'b0));
        drain();

        // zero default: handle 0 is used as is and takes its own slot
        set_default_handle(16'h0000);
        send(shaped(16'd0, 16'($urandom_range(0, 65535)), 1'b0));
        send(shaped(16'd0, 16'($urandom_range(0, 65535)), 1'b1));
        send(shaped(16'd7, 16'($urandom_range(0, 65535)), 1'b0));
        drain();

        // top default, then fill the slot table and run past its end
        set_default_handle(16'hFFFF);
        send(shaped(16'd0, 16'($urandom_range(0, 65535)), 1'b0));
        send(shaped(16'hFFFF, 16'($urandom_range(0, 65535)), 1'b1));
        for (int i = 0; i < 12; i++) begin
            send(shaped(16'h0100 + 16'(i), 16'($urandom_range(0, 65535)),
                        1'($urandom_range(0, 1))));
        end
        send(shaped(16'h4321, 16'($urandom_range(0, 65535)), 1'b0));
        send(shaped(16'd0, 16'($urandom_range(0, 65535)), 1'b1));
        drain();

        // random phases: mostly known handles so the full table keeps hitting
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            tx_quiet = (ph == 0) || (ph == 2);
            rx_quiet = (ph == 0);
            set_default_handle((ph == 0) ? 16'd1 : 16'($urandom_range(1, 65535)));
            for (int n = 0; n < PHASE_SPRITES; n++) begin
                s    = random_sprite();
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    s.texture_handle = handle_pool[$urandom_range(0, handle_pool.size() - 1)];
                end else if (pick < 8) begin
                    s.texture_handle = 16'd0;
                end
                send(s);
            end
            if (ph == 2) begin
                hold_trigger <= 1'b1;
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && quad_corners_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/sqvg_pkg.sv
rtl/core/sqvg_front.sv
rtl/core/sqvg_queue.sv
rtl/core/sqvg_back.sv
rtl/core/sprite_quad_vertex_generator.sv
rtl/core/sqvg_checker.sv
verif/tb_top.sv
